>>> hw/rtl/trv_pkg.sv
// ----------------------------------------------------------------------------
// trv_pkg: shared types, tokens and helpers for the record validator
// Status codes, result bundle, fixed field tokens and character checks.
// ----------------------------------------------------------------------------
package trv_pkg;

    // Control characters of the record framing
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Field layout
    localparam logic [2:0] LAST_FIELD = 3'd4;
    localparam logic [7:0] MAX_CORRELATION_LENGTH = 8'd128;

    // Tokens are right-aligned in a 25-character word; char 0 is the highest
    // used byte.
    localparam int unsigned TOK_CHARS = 25;
    localparam int unsigned TOK_BITS  = 8 * TOK_CHARS;

    localparam logic [4:0] LEN_MARKER = 5'd15;
    localparam logic [4:0] LEN_SCHEMA = 5'd1;
    localparam logic [4:0] LEN_KIND0  = 5'd15;
    localparam logic [4:0] LEN_KIND1  = 5'd25;
    localparam logic [4:0] LEN_OUT0   = 5'd7;
    localparam logic [4:0] LEN_OUT1   = 5'd6;

    // Marker field, given as raw byte codes
    localparam logic [TOK_BITS-1:0] TOK_MARKER = {80'd0,
        8'h4B, 8'h49, 8'h4B, 8'h4F, 8'h2D, 8'h45, 8'h58, 8'h50,
        8'h45, 8'h52, 8'h49, 8'h4D, 8'h45, 8'h4E, 8'h54};
    localparam logic [TOK_BITS-1:0] TOK_SCHEMA = {192'd0, 8'h31};
    // Kind tokens, also as raw byte codes: production gate, then
    // authorization disabled
    localparam logic [TOK_BITS-1:0] TOK_KIND0  = {80'd0,
        8'h70, 8'h72, 8'h6F, 8'h64, 8'h75, 8'h63, 8'h74, 8'h69,
        8'h6F, 8'h6E, 8'h5F, 8'h67, 8'h61, 8'h74, 8'h65};
    localparam logic [TOK_BITS-1:0] TOK_KIND1  = {
        8'h6B, 8'h33, 8'h5F, 8'h61, 8'h75, 8'h74, 8'h68, 8'h6F,
        8'h72, 8'h69, 8'h7A, 8'h61, 8'h74, 8'h69, 8'h6F, 8'h6E,
        8'h5F, 8'h64, 8'h69, 8'h73, 8'h61, 8'h62, 8'h6C, 8'h65, 8'h64};
    localparam logic [TOK_BITS-1:0] TOK_OUT0   = {144'd0, 56'("blocked")};
    localparam logic [TOK_BITS-1:0] TOK_OUT1   = {152'd0, 48'("passed")};

    // Result status, in precedence order
    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_MALFORMED   = 3'd1,
        STATUS_SCHEMA      = 3'd2,
        STATUS_EXPERIMENT  = 3'd3,
        STATUS_OUTCOME     = 3'd4,
        STATUS_CORRELATION = 3'd5,
        STATUS_CONTEXT     = 3'd6
    } trv_status_t;

    // Register index on the configuration port
    localparam logic REG_EXPECTED_KIND = 1'b0;

    // Input kind codes
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // One result transaction
    typedef struct packed {
        logic [7:0]  correlation_length;
        logic [7:0]  correlation_start;
        logic        outcome_passed;
        logic        experiment_kind;
        trv_status_t status;
    } trv_result_t;

    // Saturating byte counter step
    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // Does byte b sit at position pos of token tok of length len?
    function automatic logic tok_fits(input logic [TOK_BITS-1:0] tok,
                                      input logic [4:0] len,
                                      input logic [7:0] pos,
                                      input logic [7:0] b);
        logic [4:0] ri;
        ri = len - 5'd1 - pos[4:0];
        return (pos < {3'd0, len}) && (tok[{ri, 3'b000} +: 8] == b);
    endfunction

    // Allowed correlation characters: [A-Za-z0-9._:-]
    function automatic logic is_corr_char(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h2E || b == 8'h5F ||
               b == 8'h3A || b == 8'h2D;
    endfunction

endpackage

>>> hw/rtl/tab_record_validator_core.sv
// ----------------------------------------------------------------------------
// tab_record_validator_core: streaming validator for tab-separated records
// Byte stream in, one status transaction out per record end marker.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle: a record byte, or an end marker
// (tuser high). Each byte passes an input register and then updates the
// scanner state; an end marker passes the input register and then leaves the
// output register as one result transaction. Bytes produce no output. The
// output register lets input keep flowing while a result waits; a result only
// stalls the input when a second end marker reaches the scanner before the
// first is taken. Register 0 (byte address 0) holds the expected experiment
// kind; the user must write it only while no record is in flight; not enforced.
module tab_record_validator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] kind (1 = end of record)
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] status, [3] experiment_kind,
                                   // [4] outcome_passed, [12:5] correlation_start,
                                   // [20:13] correlation_length, [23:21] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 in_valid_reg;
    logic                 in_kind_reg;
    logic [7:0]           in_byte_reg;
    logic                 step;
    logic [1:0]           expected_kind_reg;
    logic                 out_valid_reg;
    trv_pkg::trv_result_t out_result_reg;
    trv_pkg::trv_result_t scan_result;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_kind_reg <= 2'd0;
        end else if (psel && penable && pwrite && paddr[2] == trv_pkg::REG_EXPECTED_KIND) begin
            expected_kind_reg <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == trv_pkg::REG_EXPECTED_KIND) ? {30'd0, expected_kind_reg}
                                                             : 32'd0;

    // Scanner step: bytes always go, an end marker needs room in the output
    assign step = in_valid_reg &&
                  (in_kind_reg == trv_pkg::KIND_BYTE || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    trv_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .item_kind     (in_kind_reg),
        .item_byte     (in_byte_reg),
        .expected_kind (expected_kind_reg),
        .result        (scan_result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && in_kind_reg == trv_pkg::KIND_END) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_kind_reg == trv_pkg::KIND_END) begin
            out_result_reg <= scan_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_result_reg};

endmodule

>>> hw/rtl/trv_scan.sv
// ----------------------------------------------------------------------------
// trv_scan: record scanner
// Tracks framing and field matches byte by byte and forms the end status.
// ----------------------------------------------------------------------------
module trv_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,          // one item processed this cycle
    input  logic                 item_kind,     // byte or end of record
    input  logic [7:0]           item_byte,
    input  logic [1:0]           expected_kind,
    output trv_pkg::trv_result_t result        // valid while an end item steps
);

    logic [7:0] byte_position_reg, byte_position_next;
    logic [2:0] field_number_reg, field_number_next;
    logic [7:0] char_in_field_reg, char_in_field_next;
    logic       framing_bad_reg, framing_bad_next;
    logic       line_feed_seen_reg, line_feed_seen_next;
    logic       any_byte_seen_reg, any_byte_seen_next;
    logic       marker_matches_reg, marker_matches_next;
    logic       schema_matches_reg, schema_matches_next;
    logic [1:0] kind_cand_reg, kind_cand_next;
    logic [1:0] outcome_cand_reg, outcome_cand_next;
    logic       corr_chars_ok_reg, corr_chars_ok_next;
    logic [7:0] corr_count_reg, corr_count_next;
    logic [7:0] corr_offset_reg, corr_offset_next;

    logic [7:0] pos_inc;
    logic       kind_bit;
    logic       pass_bit;
    trv_pkg::trv_status_t status;

    assign pos_inc = trv_pkg::sat_inc(byte_position_reg);

    // Next record state for one byte, or back to a clean record at the end
    always_comb begin
        byte_position_next  = byte_position_reg;
        field_number_next   = field_number_reg;
        char_in_field_next  = char_in_field_reg;
        framing_bad_next    = framing_bad_reg;
        line_feed_seen_next = line_feed_seen_reg;
        any_byte_seen_next  = any_byte_seen_reg;
        marker_matches_next = marker_matches_reg;
        schema_matches_next = schema_matches_reg;
        kind_cand_next      = kind_cand_reg;
        outcome_cand_next   = outcome_cand_reg;
        corr_chars_ok_next  = corr_chars_ok_reg;
        corr_count_next     = corr_count_reg;
        corr_offset_next    = corr_offset_reg;

        if (item_kind == trv_pkg::KIND_END) begin
            byte_position_next  = 8'd0;
            field_number_next   = 3'd0;
            char_in_field_next  = 8'd0;
            framing_bad_next    = 1'b0;
            line_feed_seen_next = 1'b0;
            any_byte_seen_next  = 1'b0;
            marker_matches_next = 1'b1;
            schema_matches_next = 1'b1;
            kind_cand_next      = 2'b11;
            outcome_cand_next   = 2'b11;
            corr_chars_ok_next  = 1'b1;
            corr_count_next     = 8'd0;
            corr_offset_next    = 8'd0;
        end else begin
            any_byte_seen_next = 1'b1;
            byte_position_next = pos_inc;
            if (line_feed_seen_reg || item_byte == trv_pkg::CH_CR) begin
                framing_bad_next = 1'b1;
            end else if (item_byte == trv_pkg::CH_LF) begin
                line_feed_seen_next = 1'b1;
            end else if (item_byte == trv_pkg::CH_TAB) begin
                // field separator: length checks, then move on
                if (field_number_reg >= trv_pkg::LAST_FIELD) begin
                    framing_bad_next = 1'b1;
                end else begin
                    case (field_number_reg)
                        3'd0: begin
                            if (char_in_field_reg != 8'd15) marker_matches_next = 1'b0;
                        end
                        3'd1: begin
                            if (char_in_field_reg != 8'd1) schema_matches_next = 1'b0;
                        end
                        3'd2: begin
                            kind_cand_next = kind_cand_reg &
                                {char_in_field_reg == 8'd25, char_in_field_reg == 8'd15};
                        end
                        default: begin
                            outcome_cand_next = outcome_cand_reg &
                                {char_in_field_reg == 8'd6, char_in_field_reg == 8'd7};
                        end
                    endcase
                    field_number_next  = field_number_reg + 3'd1;
                    char_in_field_next = 8'd0;
                    if (field_number_reg == trv_pkg::LAST_FIELD - 3'd1)
                        corr_offset_next = pos_inc;
                end
            end else begin
                // body character of the current field
                case (field_number_reg)
                    3'd0: begin
                        if (!trv_pkg::tok_fits(trv_pkg::TOK_MARKER, trv_pkg::LEN_MARKER,
                                               char_in_field_reg, item_byte))
                            marker_matches_next = 1'b0;
                    end
                    3'd1: begin
                        if (!trv_pkg::tok_fits(trv_pkg::TOK_SCHEMA, trv_pkg::LEN_SCHEMA,
                                               char_in_field_reg, item_byte))
                            schema_matches_next = 1'b0;
                    end
                    3'd2: begin
                        kind_cand_next = kind_cand_reg & {
                            trv_pkg::tok_fits(trv_pkg::TOK_KIND1, trv_pkg::LEN_KIND1,
                                              char_in_field_reg, item_byte),
                            trv_pkg::tok_fits(trv_pkg::TOK_KIND0, trv_pkg::LEN_KIND0,
                                              char_in_field_reg, item_byte)};
                    end
                    3'd3: begin
                        outcome_cand_next = outcome_cand_reg & {
                            trv_pkg::tok_fits(trv_pkg::TOK_OUT1, trv_pkg::LEN_OUT1,
                                              char_in_field_reg, item_byte),
                            trv_pkg::tok_fits(trv_pkg::TOK_OUT0, trv_pkg::LEN_OUT0,
                                              char_in_field_reg, item_byte)};
                    end
                    default: begin
                        if (!trv_pkg::is_corr_char(item_byte)) corr_chars_ok_next = 1'b0;
                        corr_count_next = trv_pkg::sat_inc(corr_count_reg);
                    end
                endcase
                char_in_field_next = trv_pkg::sat_inc(char_in_field_reg);
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg  <= 8'd0;
            field_number_reg   <= 3'd0;
            char_in_field_reg  <= 8'd0;
            framing_bad_reg    <= 1'b0;
            line_feed_seen_reg <= 1'b0;
            any_byte_seen_reg  <= 1'b0;
            marker_matches_reg <= 1'b1;
            schema_matches_reg <= 1'b1;
            kind_cand_reg      <= 2'b11;
            outcome_cand_reg   <= 2'b11;
            corr_chars_ok_reg  <= 1'b1;
            corr_count_reg     <= 8'd0;
            corr_offset_reg    <= 8'd0;
        end else if (step) begin
            byte_position_reg  <= byte_position_next;
            field_number_reg   <= field_number_next;
            char_in_field_reg  <= char_in_field_next;
            framing_bad_reg    <= framing_bad_next;
            line_feed_seen_reg <= line_feed_seen_next;
            any_byte_seen_reg  <= any_byte_seen_next;
            marker_matches_reg <= marker_matches_next;
            schema_matches_reg <= schema_matches_next;
            kind_cand_reg      <= kind_cand_next;
            outcome_cand_reg   <= outcome_cand_next;
            corr_chars_ok_reg  <= corr_chars_ok_next;
            corr_count_reg     <= corr_count_next;
            corr_offset_reg    <= corr_offset_next;
        end
    end

    // End-of-record status, first failing check wins
    assign kind_bit = kind_cand_reg[1];
    assign pass_bit = outcome_cand_reg[1];

    always_comb begin
        if (!any_byte_seen_reg || framing_bad_reg || !line_feed_seen_reg ||
            field_number_reg != trv_pkg::LAST_FIELD || !marker_matches_reg)
            status = trv_pkg::STATUS_MALFORMED;
        else if (!schema_matches_reg)
            status = trv_pkg::STATUS_SCHEMA;
        else if (kind_cand_reg == 2'b00)
            status = trv_pkg::STATUS_EXPERIMENT;
        else if (outcome_cand_reg == 2'b00)
            status = trv_pkg::STATUS_OUTCOME;
        else if (!corr_chars_ok_reg || corr_count_reg == 8'd0 ||
                 corr_count_reg > trv_pkg::MAX_CORRELATION_LENGTH)
            status = trv_pkg::STATUS_CORRELATION;
        else if (expected_kind[1] || expected_kind[0] != kind_bit)
            status = trv_pkg::STATUS_CONTEXT;
        else
            status = trv_pkg::STATUS_OK;
    end

    always_comb begin
        result.status = status;
        if (status == trv_pkg::STATUS_OK) begin
            result.experiment_kind    = kind_bit;
            result.outcome_passed     = pass_bit;
            result.correlation_start  = corr_offset_reg;
            result.correlation_length = corr_count_reg;
        end else begin
            result.experiment_kind    = 1'b0;
            result.outcome_passed     = 1'b0;
            result.correlation_start  = 8'd0;
            result.correlation_length = 8'd0;
        end
    end

endmodule

>>> verif/record_status_checker.sv
// ----------------------------------------------------------------------------
// record_status_checker: scoreboard for the tab record validator
// Follows every byte transaction on the input stream with its own copy of the
// record scanner, queues the status due at each end marker and compares each
// result transaction against the oldest queued status, field by field.
// ----------------------------------------------------------------------------
module record_status_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          pending,
    output int          failures,
    output int          checked
);
    import trv_pkg::*;

    localparam logic [7:0]  CORR_MAX = 8'd128;
    localparam int unsigned TXT_BITS = 200;

    // Field tokens, right-aligned; marker and kinds are given as byte codes
    localparam logic [TXT_BITS-1:0] MARKER_TXT = {80'd0, 8'h4B, 8'h49, 8'h4B, 8'h4F,
        8'h2D, 8'h45, 8'h58, 8'h50, 8'h45, 8'h52, 8'h49, 8'h4D, 8'h45, 8'h4E, 8'h54};
    localparam logic [TXT_BITS-1:0] SCHEMA_TXT   = {192'd0, "1"};
    localparam logic [TXT_BITS-1:0] GATE_TXT     = {80'd0, 8'h70, 8'h72, 8'h6F, 8'h64,
        8'h75, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h5F, 8'h67, 8'h61, 8'h74, 8'h65};
    localparam logic [TXT_BITS-1:0] AUTH_OFF_TXT = {8'h6B, 8'h33, 8'h5F, 8'h61, 8'h75,
        8'h74, 8'h68, 8'h6F, 8'h72, 8'h69, 8'h7A, 8'h61, 8'h74, 8'h69, 8'h6F, 8'h6E,
        8'h5F, 8'h64, 8'h69, 8'h73, 8'h61, 8'h62, 8'h6C, 8'h65, 8'h64};
    localparam logic [TXT_BITS-1:0] BLOCKED_TXT  = {144'd0, "blocked"};
    localparam logic [TXT_BITS-1:0] PASSED_TXT   = {152'd0, "passed"};

    // Scanner state of the record in flight
    logic [7:0] pos_cnt, chr_cnt, corr_cnt, corr_off;
    logic [2:0] fld;
    logic       bad_frame, lf_seen, got_byte, marker_ok, schema_ok, corr_ok;
    logic [1:0] kind_live;      // [0] production gate, [1] authorization disabled
    logic [1:0] outc_live;      // [0] blocked, [1] passed
    logic [1:0] exp_kind;

    trv_result_t status_due[$];
    int err_cnt = 0;
    int seen    = 0;

    function automatic logic [7:0] bump(input logic [7:0] v);
        if (v != 8'hFF)
            v = v + 8'd1;
        return v;
    endfunction

    // Does byte b match character idx of a token of length len?
    function automatic logic txt_match(input logic [TXT_BITS-1:0] txt, input int len,
                                       input int idx, input logic [7:0] b);
        if (idx >= len)
            return 1'b0;
        return txt[8*(len-1-idx) +: 8] == b;
    endfunction

    function automatic logic corr_char(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
               (b >= "0" && b <= "9") || b == "." || b == "_" || b == ":" || b == "-";
    endfunction

    function void clear_scan();
        pos_cnt   = '0;
        chr_cnt   = '0;
        corr_cnt  = '0;
        corr_off  = '0;
        fld       = '0;
        bad_frame = 1'b0;
        lf_seen   = 1'b0;
        got_byte  = 1'b0;
        marker_ok = 1'b1;
        schema_ok = 1'b1;
        corr_ok   = 1'b1;
        kind_live = 2'b11;
        outc_live = 2'b11;
    endfunction

    // One record byte
    function void scan_byte(input logic [7:0] b);
        got_byte = 1'b1;
        if (lf_seen || b == CH_CR) begin
            bad_frame = 1'b1;
            pos_cnt   = bump(pos_cnt);
        end else if (b == CH_LF) begin
            lf_seen = 1'b1;
            pos_cnt = bump(pos_cnt);
        end else if (b == CH_TAB) begin
            pos_cnt = bump(pos_cnt);
            if (fld >= LAST_FIELD) begin
                bad_frame = 1'b1;
            end else begin
                // a tab closes the field: check its length
                case (fld)
                    3'd0: if (chr_cnt != 8'd15) marker_ok = 1'b0;
                    3'd1: if (chr_cnt != 8'd1) schema_ok = 1'b0;
                    3'd2: begin
                        if (chr_cnt != 8'd15) kind_live[0] = 1'b0;
                        if (chr_cnt != 8'd25) kind_live[1] = 1'b0;
                    end
                    default: begin
                        if (chr_cnt != 8'd7) outc_live[0] = 1'b0;
                        if (chr_cnt != 8'd6) outc_live[1] = 1'b0;
                    end
                endcase
                fld     = fld + 3'd1;
                chr_cnt = '0;
                if (fld == LAST_FIELD)
                    corr_off = pos_cnt;
            end
        end else begin
            case (fld)
                3'd0: if (!txt_match(MARKER_TXT, 15, int'(chr_cnt), b)) marker_ok = 1'b0;
                3'd1: if (!txt_match(SCHEMA_TXT, 1, int'(chr_cnt), b)) schema_ok = 1'b0;
                3'd2: begin
                    if (!txt_match(GATE_TXT, 15, int'(chr_cnt), b)) kind_live[0] = 1'b0;
                    if (!txt_match(AUTH_OFF_TXT, 25, int'(chr_cnt), b)) kind_live[1] = 1'b0;
                end
                3'd3: begin
                    if (!txt_match(BLOCKED_TXT, 7, int'(chr_cnt), b)) outc_live[0] = 1'b0;
                    if (!txt_match(PASSED_TXT, 6, int'(chr_cnt), b)) outc_live[1] = 1'b0;
                end
                default: begin
                    if (!corr_char(b)) corr_ok = 1'b0;
                    corr_cnt = bump(corr_cnt);
                end
            endcase
            chr_cnt = bump(chr_cnt);
            pos_cnt = bump(pos_cnt);
        end
    endfunction

    // End marker: status by precedence, then back to a clean scanner
    function trv_result_t close_record();
        trv_result_t r;
        r = '0;
        if (!got_byte || bad_frame || !lf_seen || fld != LAST_FIELD || !marker_ok)
            r.status = STATUS_MALFORMED;
        else if (!schema_ok)
            r.status = STATUS_SCHEMA;
        else if (kind_live == 2'b00)
            r.status = STATUS_EXPERIMENT;
        else if (outc_live == 2'b00)
            r.status = STATUS_OUTCOME;
        else if (!corr_ok || corr_cnt == 8'd0 || corr_cnt > CORR_MAX)
            r.status = STATUS_CORRELATION;
        else if (exp_kind != {1'b0, kind_live[1]})
            r.status = STATUS_CONTEXT;
        else
            r.status = STATUS_OK;
        if (r.status == STATUS_OK) begin
            r.experiment_kind    = kind_live[1];
            r.outcome_passed     = outc_live[1];
            r.correlation_start  = corr_off;
            r.correlation_length = corr_cnt;
        end
        clear_scan();
        return r;
    endfunction

    function void cmp_field(input string name, input int unsigned want,
                            input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        trv_result_t want;
        trv_result_t got;
        if (!aresetn) begin
            clear_scan();
            exp_kind = 2'd0;
            status_due.delete();
        end else begin
            // register writes land at the access cycle
            if (psel && penable && pwrite && pready && paddr[2] == REG_EXPECTED_KIND)
                exp_kind = pwdata[1:0];

            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == KIND_END)
                    status_due.push_back(close_record());
                else
                    scan_byte(s_tdata);
            end

            if (m_tvalid && m_tready) begin
                got = m_tdata[20:0];
                seen++;
                if (status_due.size() == 0) begin
                    $error("result transaction with no record end pending (status %0d)",
                           got.status);
                    err_cnt++;
                end else begin
                    want = status_due.pop_front();
                    cmp_field("status", 32'(want.status), 32'(got.status));
                    cmp_field("experiment_kind", 32'(want.experiment_kind),
                              32'(got.experiment_kind));
                    cmp_field("outcome_passed", 32'(want.outcome_passed),
                              32'(got.outcome_passed));
                    cmp_field("correlation_start", 32'(want.correlation_start),
                              32'(got.correlation_start));
                    cmp_field("correlation_length", 32'(want.correlation_length),
                              32'(got.correlation_length));
                end
            end
        end
        pending  <= status_due.size();
        failures <= err_cnt;
        checked  <= seen;
    end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for tab_record_validator_core
// Sends directed and random byte records with end markers under three pacing
// phases and every expected_kind setting; the checker scores each status.
// ----------------------------------------------------------------------------
module tb;
    import trv_pkg::*;

    localparam int LIMIT = 400000;

    localparam logic [2:0] ADDR_EXPECTED_KIND = 3'd0;
    localparam logic [2:0] ADDR_UNUSED        = 3'd4;

    localparam logic [1:0] EXP_GATE     = 2'd0;
    localparam logic [1:0] EXP_AUTH_OFF = 2'd1;
    localparam logic [1:0] EXP_BAD2     = 2'd2;
    localparam logic [1:0] EXP_BAD3     = 2'd3;

    localparam logic SEL_GATE     = 1'b0;
    localparam logic SEL_AUTH_OFF = 1'b1;
    localparam logic SEL_BLOCKED  = 1'b0;
    localparam logic SEL_PASSED   = 1'b1;

    localparam int unsigned TXT_BITS = 200;
    localparam logic [TXT_BITS-1:0] MARKER_TXT = {80'd0, 8'h4B, 8'h49, 8'h4B, 8'h4F,
        8'h2D, 8'h45, 8'h58, 8'h50, 8'h45, 8'h52, 8'h49, 8'h4D, 8'h45, 8'h4E, 8'h54};
    localparam logic [TXT_BITS-1:0] GATE_TXT     = {80'd0, 8'h70, 8'h72, 8'h6F, 8'h64,
        8'h75, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h5F, 8'h67, 8'h61, 8'h74, 8'h65};
    localparam logic [TXT_BITS-1:0] AUTH_OFF_TXT = {8'h6B, 8'h33, 8'h5F, 8'h61, 8'h75,
        8'h74, 8'h68, 8'h6F, 8'h72, 8'h69, 8'h7A, 8'h61, 8'h74, 8'h69, 8'h6F, 8'h6E,
        8'h5F, 8'h64, 8'h69, 8'h73, 8'h61, 8'h62, 8'h6C, 8'h65, 8'h64};
    localparam logic [TXT_BITS-1:0] BLOCKED_TXT  = {144'd0, "blocked"};
    localparam logic [TXT_BITS-1:0] PASSED_TXT   = {152'd0, "passed"};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;     // [7:0] data_byte
    logic [0:0]  s_tuser  = '0;     // [0] kind
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic        s_tready, m_tvalid, pready;
    logic [23:0] m_tdata;
    logic [31:0] prdata;

    int pending, failures, checked;
    int send_idle    = 37;
    int recv_idle    = 86;
    int cycle_cnt    = 0;
    int records_sent = 0;
    int bytes_sent   = 0;

    logic [7:0] rec[$];
    string corr_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789._:-";

    tab_record_validator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    record_status_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .pending(pending), .failures(failures), .checked(checked)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic push_item(input logic k, input logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= k;
        s_tdata    <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_record();
        foreach (rec[i]) begin
            push_item(KIND_BYTE, rec[i]);
            bytes_sent++;
        end
        push_item(KIND_END, 8'($urandom_range(255)));
        records_sent++;
    endtask

    // Hold the input until every status is back and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_text(input logic [TXT_BITS-1:0] txt, input int len);
        for (int i = 0; i < len; i++)
            rec.push_back(txt[8*(len-1-i) +: 8]);
    endtask

    task automatic add_corr(input int n);
        repeat (n) rec.push_back(corr_set[$urandom_range(corr_set.len() - 1)]);
    endtask

    // Well-formed record: marker, schema, kind, outcome, correlation, LF
    task automatic build_record(input logic kind_sel, input logic out_sel, input int n);
        rec.delete();
        add_text(MARKER_TXT, 15);
        rec.push_back(CH_TAB);
        rec.push_back("1");
        rec.push_back(CH_TAB);
        if (kind_sel == SEL_AUTH_OFF)
            add_text(AUTH_OFF_TXT, 25);
        else
            add_text(GATE_TXT, 15);
        rec.push_back(CH_TAB);
        if (out_sel == SEL_PASSED)
            add_text(PASSED_TXT, 6);
        else
            add_text(BLOCKED_TXT, 7);
        rec.push_back(CH_TAB);
        add_corr(n);
        rec.push_back(CH_LF);
    endtask

    // Break a record at one random spot
    task automatic mangle();
        int at;
        logic [7:0] b;
        at = $urandom_range(rec.size() - 1);
        case ($urandom_range(3))
            0: b = 8'($urandom_range(255));
            1: b = CH_TAB;
            2: b = CH_LF;
            default: b = CH_CR;
        endcase
        case ($urandom_range(2))
            0: rec[at] = b;
            1: rec.insert(at, b);
            default: rec.delete(at);
        endcase
    endtask

    task automatic random_record();
        int pick;
        int r;
        int n;
        pick = $urandom_range(99);
        if (pick < 12) begin
            // raw noise, sometimes with a final LF
            rec.delete();
            n = $urandom_range(40);
            repeat (n) rec.push_back(8'($urandom_range(255)));
            if ($urandom_range(1))
                rec.push_back(CH_LF);
        end else begin
            r = $urandom_range(99);
            if (r < 78)
                n = $urandom_range(12, 1);
            else if (r < 92)
                n = $urandom_range(136, 120);
            else if (r < 97)
                n = 0;
            else
                n = $urandom_range(280, 200);
            build_record(1'($urandom_range(1)), 1'($urandom_range(1)), n);
            if (pick < 50)
                mangle();
            if (pick < 20)
                mangle();
        end
        send_record();
    endtask

    initial begin
        logic [1:0] kind_order [4];

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed records, expected_kind at its reset value ----
        rec.delete();
        send_record();                                  // empty record
        build_record(SEL_GATE, SEL_PASSED, 1);          // shortest correlation
        send_record();
        build_record(SEL_AUTH_OFF, SEL_BLOCKED, 5);     // kind differs from register
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 129);        // correlation one too long
        send_record();
        build_record(SEL_GATE, SEL_BLOCKED, 0);         // empty correlation
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 260);        // counters saturate
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // byte after the LF
        rec.push_back("z");
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // no final LF
        rec.delete(rec.size() - 1);
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // CR LF ending
        rec.insert(rec.size() - 1, CH_CR);
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // tab inside correlation
        rec.insert(rec.size() - 1, CH_TAB);
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // LF early in the record
        rec.insert(5, CH_LF);
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // only four fields
        rec.delete(40);
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // wrong marker
        rec[0] = "k";
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // wrong schema digit
        rec[16] = "2";
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // schema too long
        rec.insert(17, "1");
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // kind token typo
        rec[20] = "X";
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // kind token one short
        rec.delete(32);
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 4);          // outcome token typo
        rec[36] = "X";
        send_record();
        build_record(SEL_GATE, SEL_BLOCKED, 5);         // illegal correlation char
        rec[rec.size() - 2] = 8'h20;
        send_record();

        // write to an unused address must not touch expected_kind
        drain();
        reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        build_record(SEL_AUTH_OFF, SEL_PASSED, 3);
        send_record();

        drain();
        reg_write(ADDR_EXPECTED_KIND, {30'd0, EXP_AUTH_OFF});
        build_record(SEL_AUTH_OFF, SEL_BLOCKED, 128);   // longest correlation, ok
        send_record();
        build_record(SEL_GATE, SEL_PASSED, 7);
        send_record();

        drain();
        reg_write(ADDR_EXPECTED_KIND, {30'd0, EXP_BAD2});
        build_record(SEL_GATE, SEL_PASSED, 7);
        send_record();

        drain();
        reg_write(ADDR_EXPECTED_KIND, {30'h3FFF_FFFF, EXP_BAD3});
        build_record(SEL_AUTH_OFF, SEL_PASSED, 7);
        send_record();

        // ---- random records under the other two pacing phases ----
        kind_order = '{EXP_BAD2, EXP_GATE, EXP_BAD3, EXP_AUTH_OFF};
        for (int ph = 1; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle = 86;
                recv_idle = 37;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int k = 0; k < 2; k++) begin
                drain();
                reg_write(ADDR_EXPECTED_KIND, {30'd0, kind_order[2*(ph-1)+k]});
                random_record();
            end
        end

        drain();
        $display("Sent %0d records (%0d bytes) under three pacing phases and all four",
                 records_sent, bytes_sent);
        $display("expected_kind values; %0d status transactions compared, %0d mismatches.",
                 checked, failures);
        if (failures == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
